// ===== rtl/rsa_modular_exponentiation_assert.svh =====
// Assertion macros shared by the checker of the modular exponentiation block.
// Depends on nothing; included by the checker file only.
`ifndef RSA_MODULAR_EXPONENTIATION_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RSAME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, switched off while reset is held.
`define RSAME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== rtl/rsame_pkg.sv =====
// Shared constants, types and the sequencer state type of the modular exponentiation block.
// Depends on nothing; every other file of the block but the assertion header imports it.
package rsame_pkg;

    localparam int WIDTH     = 32;
    localparam int CNT_W     = $clog2(WIDTH);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = CFG_IDX_W'(2);

    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(2);
    localparam logic [WIDTH-1:0] EXP_RESET     = WIDTH'(1);

    // Request type codes.
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_FINISH
    } rsame_state_t;

    typedef struct packed {
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] message;
    } rsame_job_t;

endpackage

// ===== rtl/rsame_req_if.sv =====
// Request channel of the modular exponentiation block: valid, ready and the request fields.
// Depends on rsame_pkg.
interface rsame_req_if
    import rsame_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [WIDTH-1:0] message_value;

    modport source (output valid, output req_type, output message_value, input ready);
    modport sink   (input valid, input req_type, input message_value, output ready);
endinterface

// ===== rtl/rsame_res_if.sv =====
// Result channel of the modular exponentiation block: valid, ready and the result value.
// Depends on rsame_pkg.
interface rsame_res_if
    import rsame_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

// ===== rtl/rsame_engine.sv =====
// Exponentiation engine: one modular add unit shared by reduction and shift-add multiplication.
// Depends on rsame_pkg.
module rsame_engine
    import rsame_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  rsame_job_t       job,
    output logic             done_valid,
    input  logic             done_ready,
    output logic [WIDTH-1:0] result
);

    rsame_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] bit_reg, bit_next;
    logic             sq_reg, sq_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] msg_reg, msg_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] prod_reg, prod_next;

    logic [WIDTH-1:0] unit_x;
    logic [WIDTH-1:0] unit_y;
    logic             unit_cin;
    logic [WIDTH:0]   unit_sum;
    logic [WIDTH:0]   unit_diff;
    logic [WIDTH-1:0] unit_out;

    // Both operands stay below the modulus, so one conditional subtraction reduces the sum.
    assign unit_sum  = {1'b0, unit_x} + {1'b0, unit_y} + {{WIDTH{1'b0}}, unit_cin};
    assign unit_diff = unit_sum - {1'b0, mod_reg};
    assign unit_out  = (unit_sum >= {1'b0, mod_reg}) ? unit_diff[WIDTH-1:0]
                                                     : unit_sum[WIDTH-1:0];

    assign result = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg  <= mod_next;
        exp_reg  <= exp_next;
        msg_reg  <= msg_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        sq_next    = sq_reg;
        mod_next   = mod_reg;
        exp_next   = exp_reg;
        msg_next   = msg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        unit_x     = prod_reg;
        unit_y     = '0;
        unit_cin   = 1'b0;
        job_ready  = 1'b0;
        done_valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    mod_next = job.modulus;
                    exp_next = job.exponent;
                    msg_next = job.message;
                    acc_next = '0;
                    cnt_next = CNT_TOP;
                    // A zero modulus cannot reduce anything and gives zero at once.
                    state_next = (job.modulus == '0) ? ST_FINISH : ST_REDUCE;
                end
            end

            ST_REDUCE:
            begin
                // Restoring remainder: shift one message bit in, subtract when it fits.
                unit_x   = acc_reg;
                unit_y   = acc_reg;
                unit_cin = msg_reg[cnt_reg];
                acc_next = unit_out;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    base_next = unit_out;
                    if (exp_reg[WIDTH-1:1] != '0)
                    begin
                        acc_next   = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                        bit_next   = CNT_TOP;
                        sq_next    = 1'b1;
                        prod_next  = '0;
                        cnt_next   = CNT_TOP;
                        state_next = ST_MUL_DBL;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_MUL_DBL:
            begin
                unit_x     = prod_reg;
                unit_y     = prod_reg;
                prod_next  = unit_out;
                state_next = ST_MUL_ADD;
            end

            ST_MUL_ADD:
            begin
                // The multiplier operand is always the accumulator; the multiplicand is the
                // accumulator itself when squaring and the reduced base otherwise.
                unit_x     = prod_reg;
                unit_y     = acc_reg[cnt_reg] ? (sq_reg ? acc_reg : base_reg) : '0;
                prod_next  = unit_out;
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = ST_MUL_DBL;
                if (cnt_reg == '0)
                begin
                    acc_next  = unit_out;
                    prod_next = '0;
                    cnt_next  = CNT_TOP;
                    if (sq_reg && exp_reg[bit_reg])
                    begin
                        sq_next = 1'b0;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_next = bit_reg - CNT_W'(1);
                        sq_next  = 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                done_valid = 1'b1;
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rsa_modular_exponentiation.sv =====
// Steps: a zero modulus finishes at once; an exponent below two ends after the reduction; otherwise
// a squaring per exponent bit and a multiplication per set bit, on one shared modular adder.
// One request at a time; the next is taken as soon as the result sits in the output register.
// Reset clears the sequencer and output valid and sets modulus 2 and both exponents 1.
// Holds the configuration registers and the output register; depends on rsame_pkg,
// rsame_req_if, rsame_res_if and rsame_engine.
module rsa_modular_exponentiation
    import rsame_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    rsame_req_if.sink            req,
    rsame_res_if.source          res
);

    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic [WIDTH-1:0] pub_exp_reg, pub_exp_next;
    logic [WIDTH-1:0] priv_exp_reg, priv_exp_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] result_reg, result_next;

    rsame_job_t       job;
    logic             done_valid;
    logic             done_ready;
    logic [WIDTH-1:0] engine_result;

    always_comb
    begin
        modulus_next  = modulus_reg;
        pub_exp_next  = pub_exp_reg;
        priv_exp_next = priv_exp_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MODULUS:     modulus_next  = cfg_data;
                REG_PUBLIC_EXP:  pub_exp_next  = cfg_data;
                REG_PRIVATE_EXP: priv_exp_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        job.modulus  = modulus_reg;
        job.exponent = (req.req_type == REQ_DECRYPT) ? priv_exp_reg : pub_exp_reg;
        job.message  = req.message_value;
    end

    rsame_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (req.valid),
        .job_ready  (req.ready),
        .job        (job),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .result     (engine_result)
    );

    assign done_ready = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (done_valid && done_ready)
        begin
            out_valid_next = 1'b1;
            result_next    = engine_result;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            pub_exp_reg   <= EXP_RESET;
            priv_exp_reg  <= EXP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            pub_exp_reg   <= pub_exp_next;
            priv_exp_reg  <= priv_exp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.result_value = result_reg;

endmodule

// ===== rtl/rsame_checker.sv =====
// Port-level checker for the modular exponentiation block and its bind to the top level.
// Depends on rsame_pkg and rsa_modular_exponentiation_assert.svh.
`include "rsa_modular_exponentiation_assert.svh"

module rsame_port_checker
    import rsame_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [WIDTH-1:0] result_value
);

    // An accepted request keeps the block busy for at least the following cycle.
    `RSAME_ASSERT_NEXT(a_busy_after_request, clk, rst_n, req_valid && req_ready, !req_ready)

    // A new result only appears right after the block was busy with its request, not ready for another.
    `RSAME_ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(res_valid), $past(!req_ready))

    // A result that is not taken stays on offer unchanged.
    `RSAME_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && !res_ready, res_valid && $stable(result_value))

endmodule

bind rsa_modular_exponentiation rsame_port_checker u_rsame_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .result_value (res.result_value)
);

// ===== tb/rsame_checker.sv =====
// Checker for the modular exponentiation block: follows the register writes, predicts
// every request's result and compares it with what the result channel delivers.
// Depends on rsame_pkg, rsame_req_if and rsame_res_if.
module rsame_checker
    import rsame_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    rsame_req_if                 req,
    rsame_res_if                 res,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic             decrypt;
        logic [WIDTH-1:0] message;
        logic [WIDTH-1:0] result;
    } awaited_t;

    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] public_exp;
    logic [WIDTH-1:0] private_exp;
    awaited_t         awaited_results[$];

    function automatic logic [WIDTH-1:0] power_mod(input logic [WIDTH-1:0] value,
                                                   input logic [WIDTH-1:0] power,
                                                   input logic [WIDTH-1:0] n);
        logic [2*WIDTH-1:0] wide_n;
        logic [2*WIDTH-1:0] base;
        logic [2*WIDTH-1:0] acc;
        if (n == '0)
            return '0;
        wide_n = n;
        base   = value % wide_n;
        // An exponent of zero or one gives the reduced message, not one.
        if (power < 2)
            return base[WIDTH-1:0];
        acc = (wide_n == 1) ? '0 : 1;
        // Products of two values below n always fit in twice the width.
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % wide_n;
            if (power[i])
                acc = (acc * base) % wide_n;
        end
        return acc[WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what, input awaited_t want,
                                   input logic [WIDTH-1:0] got);
        $display("%0t: %s: message %h decrypt %0b gave %h, wanted %h",
                 $time, what, want.message, want.decrypt, got, want.result);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        awaited_t want;
        awaited_t entry;
        if (!rst_n)
        begin
            modulus     = MODULUS_RESET;
            public_exp  = EXP_RESET;
            private_exp = EXP_RESET;
            awaited_results.delete();
            errors      = 0;
        end
        else
        begin
            // A result leaves before a request of the same edge is booked, as the
            // result always belongs to an earlier request.
            if (res.valid && res.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    want = '0;
                    report_mismatch("result with no request waiting", want, res.result_value);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (res.result_value !== want.result)
                        report_mismatch("wrong result_value", want, res.result_value);
                end
            end
            if (req.valid && req.ready)
            begin
                entry.decrypt = (req.req_type == REQ_DECRYPT);
                entry.message = req.message_value;
                entry.result  = power_mod(req.message_value,
                                          entry.decrypt ? private_exp : public_exp, modulus);
                awaited_results.push_back(entry);
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_MODULUS:     modulus     = cfg_data;
                    REG_PUBLIC_EXP:  public_exp  = cfg_data;
                    REG_PRIVATE_EXP: private_exp = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the modular exponentiation testbench: clock, reset, key loading, request
// stimulus, result stalls, watchdog and verdict; checking is done in rsame_checker.
// Depends on rsame_pkg, both channel interfaces, rsame_checker and the block itself.
module tb_top;
    import rsame_pkg::*;

    localparam int HOLD_CYCLES    = 10000;
    localparam int STALL_LIMIT    = 60000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 24;
    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    logic                 steady;
    int                   hold_asks;

    rsame_req_if req_ch();
    rsame_res_if res_ch();

    rsa_modular_exponentiation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .res          (res_ch)
    );

    rsame_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .res          (res_ch),
        .errors       (errors),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    task automatic send_request(input logic kind, input logic [WIDTH-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.message_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stops offering requests and waits until every result is back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic load_key(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] e,
                            input logic [WIDTH-1:0] d);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_MODULUS;
        cfg_data     <= n;
        @(posedge clk);
        cfg_index    <= REG_PUBLIC_EXP;
        cfg_data     <= e;
        @(posedge clk);
        cfg_index    <= REG_PRIVATE_EXP;
        cfg_data     <= d;
        @(posedge clk);
        cfg_index    <= REG_SPARE;
        cfg_data     <= $urandom;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: a fresh stall after every result, and a long hold-off on request.
    initial
    begin : result_side
        int res_wait;
        int hold_left;
        int hold_seen;
        res_wait  = 0;
        hold_left = 0;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                res_wait = steady ? 0 : $urandom_range(0, 9);
            else if (res_wait != 0)
                res_wait--;
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left != 0)
                hold_left--;
            res_ch.ready <= (res_wait == 0) && (hold_left == 0);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [WIDTH-1:0] n;
        logic [WIDTH-1:0] e;
        logic [WIDTH-1:0] d;
        logic [WIDTH-1:0] msg;
        logic             kind;
        int               p;
        int               i;
        rst_n                <= 1'b0;
        cfg_write_en         <= 1'b0;
        cfg_index            <= REG_MODULUS;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ENCRYPT;
        req_ch.message_value <= '0;
        steady               <= 1'b0;
        hold_asks            <= 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Values after reset: modulus two, both exponents one.
        send_request(REQ_ENCRYPT, 32'h0000_0000);
        send_request(REQ_DECRYPT, 32'h0000_0001);
        send_request(REQ_ENCRYPT, 32'hFFFF_FFFF);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFE);
        drain();

        // A zero modulus cannot reduce and must give zero.
        load_key(32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF);
        send_request(REQ_ENCRYPT, 32'h0000_007B);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        drain();

        // A modulus of one gives zero whatever the exponent.
        load_key(32'h0000_0001, 32'h0000_0003, 32'h0000_0000);
        send_request(REQ_ENCRYPT, 32'h0000_0007);
        send_request(REQ_DECRYPT, 32'hFFFF_FFFF);
        send_request(REQ_ENCRYPT, 32'h0000_0000);
        drain();

        // Exponents of zero and one with the largest modulus.
        load_key(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        send_request(REQ_ENCRYPT, 32'hFFFF_FFFF);
        send_request(REQ_ENCRYPT, 32'hFFFF_FFFE);
        send_request(REQ_DECRYPT, 32'h8000_0000);
        drain();

        // A textbook key pair, with one message above the modulus.
        load_key(32'd3233, 32'd17, 32'd2753);
        send_request(REQ_ENCRYPT, 32'd65);
        send_request(REQ_DECRYPT, 32'd2790);
        send_request(REQ_ENCRYPT, 32'd3298);
        send_request(REQ_DECRYPT, 32'd0);
        send_request(REQ_ENCRYPT, 32'd1);
        drain();

        // Largest exponent against a large prime modulus.
        load_key(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'h0000_0002);
        send_request(REQ_ENCRYPT, 32'hFFFF_FFFA);
        send_request(REQ_DECRYPT, 32'h1234_5678);
        send_request(REQ_ENCRYPT, 32'hFFFF_FFFF);
        send_request(REQ_DECRYPT, 32'hAAAA_AAAA);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                n = $urandom_range(2, 5000);
            else
                n = $urandom;
            if (n < 2)
                n = 2;
            e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom;
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom;
            steady <= (p == 3);
            // The results back up while the receiver holds off, so requests stall.
            if (p == 2)
                hold_asks <= hold_asks + 1;
            load_key(n, e, d);
            for (i = 0; i < PHASE_REQUESTS; i++)
            begin
                if (p == 1 && i == PHASE_REQUESTS / 2)
                    drain();
                msg  = $urandom_range(0, 1) ? $urandom : ($urandom % n);
                kind = $urandom_range(0, 1) ? REQ_DECRYPT : REQ_ENCRYPT;
                send_request(kind, msg);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rsame_pkg.sv
rtl/rsame_req_if.sv
rtl/rsame_res_if.sv
rtl/rsame_engine.sv
rtl/rsa_modular_exponentiation.sv
rtl/rsame_checker.sv
tb/rsame_checker.sv
tb/tb_top.sv
